### hw/rtl/word_letter_budget_filter_defines.svh
// Assertion macros for the word letter budget filter.
`ifndef WORD_LETTER_BUDGET_FILTER_DEFINES_SVH
`define WORD_LETTER_BUDGET_FILTER_DEFINES_SVH

`ifndef ASSERT_OFF
// Checked only while out of reset.
`define WLBF_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Checked at every edge, reset included.
`define WLBF_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define WLBF_ASSERT(name, prop, msg)
`define WLBF_ASSERT_ALWAYS(name, prop, msg)
`endif

`endif

### hw/rtl/wlbf_pkg.sv
package wlbf_pkg;

  localparam int unsigned MODE_W      = 2;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned CNT_W       = 8;
  localparam int unsigned TBL_DEPTH   = 256;
  localparam int unsigned WORD_LEN_W  = 10;
  localparam int unsigned WORD_LEN_MAX = 1023;
  localparam int unsigned OUT_TDATA_W = 16;

  localparam logic [CNT_W-1:0] SELECTION_CAPACITY = 8'd255;
  localparam logic [CNT_W-1:0] CNT_MAX            = 8'd255;

  typedef enum logic [MODE_W-1:0] {
    MODE_TEXT  = 2'd0,
    MODE_ADD   = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_END   = 2'd3
  } wlbf_mode_e;

  typedef struct packed {
    logic              en;
    logic [BYTE_W-1:0] addr;
    logic [CNT_W-1:0]  data;
  } wlbf_wr_t;

  function automatic logic is_letter(input logic [BYTE_W-1:0] b);
    return (b inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]});
  endfunction

  function automatic logic is_blank(input logic [BYTE_W-1:0] b);
    return (b inside {8'h20, [8'h09:8'h0D]});
  endfunction

  // ^ ? * . $ { } [ ] ( ) backslash
  function automatic logic is_meta(input logic [BYTE_W-1:0] b);
    return (b inside {8'h5E, 8'h3F, 8'h2A, 8'h2E, 8'h24, 8'h7B, 8'h7D,
                      8'h5B, 8'h5D, 8'h28, 8'h29, 8'h5C});
  endfunction

endpackage

### hw/rtl/wlbf_count_table.sv
module wlbf_count_table (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          rd_en_i,
  input  logic [wlbf_pkg::BYTE_W-1:0]   rd_addr_i,
  input  wlbf_pkg::wlbf_wr_t            wr_i,
  input  logic                          clr_i,
  output logic [wlbf_pkg::CNT_W-1:0]    rd_data_o
);
  import wlbf_pkg::*;

  logic [CNT_W-1:0]     mem [TBL_DEPTH];
  logic [TBL_DEPTH-1:0] vld_q;
  logic [CNT_W-1:0]     mem_rd_q;
  logic                 vld_rd_q;
  logic                 byp_q;
  logic [CNT_W-1:0]     byp_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      mem_rd_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (clr_i) begin
      vld_q <= '0;
    end else if (wr_i.en) begin
      vld_q[wr_i.addr] <= 1'b1;
    end
  end

  // forward a write or clear landing on the same edge as the read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_rd_q   <= 1'b0;
      byp_q      <= 1'b0;
      byp_data_q <= '0;
    end else if (rd_en_i) begin
      vld_rd_q   <= vld_q[rd_addr_i];
      byp_q      <= clr_i || (wr_i.en && (wr_i.addr == rd_addr_i));
      byp_data_q <= clr_i ? '0 : wr_i.data;
    end
  end

  assign rd_data_o = byp_q ? byp_data_q : (vld_rd_q ? mem_rd_q : '0);

endmodule

### hw/rtl/word_letter_budget_filter.sv
// Word letter budget filter.
// Input stream: s_axis_tuser_i carries the mode (text byte, add selection
// character, clear selection, end of stream), s_axis_tdata_i the byte.
// Text bytes are split into alphanumeric words; each finished word gives
// one output word: tdata[0] = accepted (spelt within the selection
// counts), tdata[10:1] = word length. An end word, or a non-blank
// separator outside a word, also gives one (length zero if no word is
// open). No output while the selection is empty. Selection and clear
// words never produce output. The accepting edge loads the byte and its
// table reads into a stage register; the word is resolved there and the
// verdict is loaded into the output register once that register is free.
// Throughput: one input word per cycle while the output is not stalled;
// each letter byte of a word within budget does one read-modify-write of
// the usage table, forwarded between neighbours.
// Reset clears all counts at once through per-entry valid bits, so the
// block is ready right after reset. When the receiver stalls, the
// output register holds; a finishing word waits in the stage register
// and input stalls behind it, other words keep flowing.
`include "word_letter_budget_filter_defines.svh"

module word_letter_budget_filter #(
  parameter int unsigned MAX_WORD_LEN = 1023
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  logic [wlbf_pkg::BYTE_W-1:0]        s_axis_tdata_i,  // byte_value
  input  logic [wlbf_pkg::MODE_W-1:0]        s_axis_tuser_i,  // mode
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // [0] accepted, [10:1] word_length, [15:11] zero
  output logic [wlbf_pkg::OUT_TDATA_W-1:0]   m_axis_tdata_o
);
  import wlbf_pkg::*;

  localparam int unsigned LEN_W = $clog2(MAX_WORD_LEN + 1);
  localparam int unsigned EXT_W = (LEN_W > WORD_LEN_W) ? LEN_W : WORD_LEN_W;

  logic              s1_valid_q;
  logic [MODE_W-1:0] s1_mode_q;
  logic [BYTE_W-1:0] s1_byte_q;

  logic              in_word_q, in_word_d;
  logic              failed_q, failed_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic [CNT_W-1:0]  total_q, total_d;

  logic                  m_valid_q;
  logic                  m_acc_q;
  logic [WORD_LEN_W-1:0] m_len_q;

  logic             in_accept;
  logic             out_free;
  logic             s1_fire;
  logic             produces;
  logic             do_add, do_finish, do_sel_add, do_sel_clr;
  logic             letter, blank, meta;
  logic [CNT_W-1:0] sel_cnt, use_cnt;
  wlbf_wr_t         sel_wr, use_wr;
  wlbf_mode_e       mode;
  logic [EXT_W-1:0] len_ext;
  logic [WORD_LEN_W-1:0] len_out;

  assign out_free        = !m_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = !s1_valid_q || s1_fire;
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;

  wlbf_count_table u_sel_tbl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_accept),
    .rd_addr_i (s_axis_tdata_i),
    .wr_i      (sel_wr),
    .clr_i     (s1_fire && do_sel_clr),
    .rd_data_o (sel_cnt)
  );

  wlbf_count_table u_use_tbl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_accept),
    .rd_addr_i (s_axis_tdata_i),
    .wr_i      (use_wr),
    .clr_i     (s1_fire && do_finish),
    .rd_data_o (use_cnt)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      s1_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_mode_q <= s_axis_tuser_i;
      s1_byte_q <= s_axis_tdata_i;
    end
  end

  always_comb begin
    mode       = wlbf_mode_e'(s1_mode_q);
    letter     = is_letter(s1_byte_q);
    blank      = is_blank(s1_byte_q);
    meta       = is_meta(s1_byte_q);
    do_add     = 1'b0;
    do_finish  = 1'b0;
    do_sel_add = 1'b0;
    do_sel_clr = 1'b0;
    case (mode)
      MODE_TEXT: begin
        if (!in_word_q) begin
          if (letter) begin
            do_add = 1'b1;
          end else if (!blank) begin
            do_finish = 1'b1;
          end
        end else if (letter && (len_q < LEN_W'(MAX_WORD_LEN))) begin
          do_add = 1'b1;
        end else begin
          do_finish = 1'b1;
        end
      end
      MODE_ADD: begin
        do_sel_add = (s1_byte_q != '0) && !blank && !meta &&
                     (total_q < SELECTION_CAPACITY);
      end
      MODE_CLEAR: do_sel_clr = 1'b1;
      MODE_END:   do_finish  = 1'b1;
      default: ;
    endcase
  end

  assign produces = do_finish && (total_q != '0);
  assign s1_fire  = s1_valid_q && (!produces || out_free);

  always_comb begin
    in_word_d = in_word_q;
    failed_d  = failed_q;
    len_d     = len_q;
    total_d   = total_q;
    use_wr    = '{en: 1'b0, addr: s1_byte_q, data: use_cnt + CNT_W'(1)};
    sel_wr    = '{en: 1'b0, addr: s1_byte_q,
                  data: (sel_cnt == CNT_MAX) ? sel_cnt : sel_cnt + CNT_W'(1)};
    if (s1_fire) begin
      if (do_add) begin
        in_word_d = 1'b1;
        len_d     = len_q + LEN_W'(1);
        if (!failed_q) begin
          if (use_cnt < sel_cnt) begin
            use_wr.en = 1'b1;
          end else begin
            failed_d = 1'b1;
          end
        end
      end
      if (do_finish) begin
        in_word_d = 1'b0;
        failed_d  = 1'b0;
        len_d     = '0;
      end
      if (do_sel_add) begin
        sel_wr.en = 1'b1;
        total_d   = total_q + CNT_W'(1);
      end
      if (do_sel_clr) begin
        total_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_word_q <= 1'b0;
      failed_q  <= 1'b0;
      len_q     <= '0;
      total_q   <= '0;
    end else begin
      in_word_q <= in_word_d;
      failed_q  <= failed_d;
      len_q     <= len_d;
      total_q   <= total_d;
    end
  end

  assign len_ext = EXT_W'(len_q);
  assign len_out = (len_ext > EXT_W'(WORD_LEN_MAX)) ? WORD_LEN_W'(WORD_LEN_MAX)
                                                    : len_ext[WORD_LEN_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (s1_fire && produces) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && produces) begin
      m_acc_q <= !failed_q;
      m_len_q <= len_out;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {(OUT_TDATA_W - WORD_LEN_W - 1)'(0), m_len_q, m_acc_q};

  `WLBF_ASSERT(a_result_from_stage, $rose(m_axis_tvalid_o) |-> $past(s1_valid_q),
               "result without a word in the stage register")
  `WLBF_ASSERT(a_idle_word_clean, !in_word_q |-> (len_q == '0) && !failed_q,
               "word state left over outside a word")
  `WLBF_ASSERT(a_stall_holds, (s1_valid_q && !s1_fire) |=>
               (s1_valid_q && $stable(s1_byte_q) && $stable(s1_mode_q)),
               "stalled stage word changed")
  `WLBF_ASSERT_ALWAYS(a_reset_no_output, !rst_ni |-> !m_axis_tvalid_o,
                      "output valid during reset")

endmodule
